// ----- sv/bsa_pkg.sv -----
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int MAX_PAGES_DEF   = 8;
    localparam int PAGE_BLOCKS     = 64;
    localparam int PAGES_W         = 4;
    localparam int DIV_STEPS       = 32;

    localparam logic [15:0] BPB_RESET = 16'd4096;
    localparam logic [7:0]  HDR_RESET = 8'd16;
    localparam logic [3:0]  TAG_RESET = 4'd10;

    localparam logic [1:0] REG_BPB = 2'd0;
    localparam logic [1:0] REG_HDR = 2'd1;
    localparam logic [1:0] REG_TAG = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_SPAN    = 2'd2;
    localparam logic [1:0] STAT_CORRUPT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_REL,
        ST_SEARCH,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MOP_NONE,
        MOP_CLAIM,
        MOP_FREE,
        MOP_OPEN
    } map_op_t;

    typedef struct packed {
        map_op_t              op;
        logic [PAGES_W-1:0]   page;
        logic [63:0]          mask;
        logic [5:0]           amt;
    } map_cmd_t;

    // Run of n ones starting at bit 0.
    function automatic logic [63:0] run_mask(input logic [5:0] n);
        return ~({64{1'b1}} << n);
    endfunction

endpackage

// ----- sv/bsa_divider.sv -----
`timescale 1ns / 1ps

module bsa_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [15:0] remainder
);
    import bsa_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quot_reg;
    logic [15:0] rem_reg;
    logic [15:0] dvsr_reg;

    logic [16:0] r_shift;
    logic [17:0] diff;
    logic        ge;
    logic [15:0] rem_next;
    logic [31:0] quot_next;

    // One restoring step per cycle: shift in the next dividend bit, try a subtract.
    assign r_shift   = {rem_reg, quot_reg[31]};
    assign diff      = {1'b0, r_shift} - {2'b00, dvsr_reg};
    assign ge        = ~diff[17];
    assign rem_next  = ge ? diff[15:0] : r_shift[15:0];
    assign quot_next = {quot_reg[30:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ----- sv/bsa_map.sv -----
`timescale 1ns / 1ps

module bsa_map #(
    parameter int MAX_PAGES = bsa_pkg::MAX_PAGES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bsa_pkg::map_cmd_t          cmd,
    output logic                       fit,
    output logic [bsa_pkg::PAGES_W-1:0] pages_open
);
    import bsa_pkg::*;

    localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    logic [63:0]        map_reg [MAX_PAGES];
    logic [PAGES_W-1:0] pages_open_reg;
    logic [PAGES_W-1:0] pages_open_next;

    logic [127:0]     shifted;
    logic [63:0]      run_bits;
    logic [63:0]      rd_word;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_en;
    logic [63:0]      map_word_next;

    // Shared shifter: places the run at its start bit; anything past bit 63 spills high.
    assign shifted  = {64'd0, cmd.mask} << cmd.amt;
    assign run_bits = shifted[63:0];

    assign rd_idx  = cmd.page[IDX_W-1:0];
    assign rd_word = (cmd.page < PAGES_W'(MAX_PAGES)) ? map_reg[rd_idx] : '0;

    // A run fits only if it stays inside the page and every covered block is free.
    assign fit = ~(|shifted[127:64]) && ((rd_word & run_bits) == run_bits);

    always_comb begin
        wr_en           = 1'b0;
        wr_idx          = rd_idx;
        map_word_next   = rd_word;
        pages_open_next = pages_open_reg;
        unique case (cmd.op)
            MOP_CLAIM: begin
                wr_en         = fit;
                map_word_next = rd_word & ~run_bits;
            end
            MOP_FREE: begin
                wr_en         = 1'b1;
                map_word_next = rd_word | run_bits;
            end
            MOP_OPEN: begin
                wr_en           = 1'b1;
                wr_idx          = pages_open_reg[IDX_W-1:0];
                map_word_next   = ~cmd.mask;
                pages_open_next = pages_open_reg + PAGES_W'(1);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < MAX_PAGES; p++) begin
                map_reg[p] <= '1;
            end
            pages_open_reg <= PAGES_W'(1);
        end else begin
            if (wr_en) begin
                map_reg[wr_idx] <= map_word_next;
            end
            pages_open_reg <= pages_open_next;
        end
    end

    assign pages_open = pages_open_reg;

    a_open_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == MOP_OPEN |-> pages_open_reg < PAGES_W'(MAX_PAGES))
        else $error("page opened with every page already open");

    a_open_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pages_open_reg >= PAGES_W'(1) && pages_open_reg <= PAGES_W'(MAX_PAGES))
        else $error("open page count out of range");

endmodule

// ----- sv/bitmap_span_allocator.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Signals
// config    in         psel penable pwrite paddr pwdata prdata pready (APB-style)
// request   in         s_valid s_ready s_action s_request_bytes s_release_*
// result    out        m_valid m_ready m_status m_grant_* m_byte_offset
//
// A release request is checked and applied in ST_REL, then waits in ST_OUT to load its result.
// An allocate request first runs the bit-serial block-count divide, then tests start
// positions one at a time (up to 64 per open page) on the shared run shifter.
// Synchronous active-low reset frees every block and opens page 0; no sweep is needed.
// One request is in flight at a time; a new request is taken while a result still waits.

module bitmap_span_allocator #(
    parameter int MAX_PAGES = bsa_pkg::MAX_PAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [31:0] s_request_bytes,
    input  logic [3:0]  s_release_tag,
    input  logic [5:0]  s_release_blocks,
    input  logic [2:0]  s_release_page,
    input  logic [5:0]  s_release_start,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_grant_page,
    output logic [5:0]  m_grant_start,
    output logic [5:0]  m_grant_blocks,
    output logic [21:0] m_byte_offset
);
    import bsa_pkg::*;

    // Configuration registers.
    logic [15:0] bpb_reg;
    logic [7:0]  hdr_reg;
    logic [3:0]  ctag_reg;
    logic        cfg_wr;

    // Sequencer.
    state_t      state_reg, state_next;
    logic [3:0]  rel_tag_reg;
    logic [5:0]  rel_blocks_reg;
    logic [2:0]  rel_page_reg;
    logic [5:0]  rel_start_reg;
    logic [63:0] mask_reg, mask_next;
    logic [5:0]  span_reg, span_next;
    logic [PAGES_W-1:0] page_cnt_reg, page_cnt_next;
    logic [5:0]  start_cnt_reg, start_cnt_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [2:0]  res_page_reg, res_page_next;
    logic [5:0]  res_start_reg, res_start_next;
    logic [5:0]  res_blocks_reg, res_blocks_next;
    logic        out_load;
    logic        accept;

    // Result register.
    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [2:0]  m_grant_page_reg;
    logic [5:0]  m_grant_start_reg;
    logic [5:0]  m_grant_blocks_reg;
    logic [21:0] m_byte_offset_reg;

    // Divider and map.
    logic        div_start;
    logic        div_done;
    logic [15:0] div_divisor;
    logic [31:0] div_quot;
    logic [15:0] div_rem;
    logic        round_up;
    logic        too_large;
    logic [5:0]  span_calc;

    map_cmd_t           map_cmd;
    logic               map_fit;
    logic [PAGES_W-1:0] pages_open;

    logic [16:0] stride;
    logic [22:0] offset_full;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpb_reg  <= BPB_RESET;
            hdr_reg  <= HDR_RESET;
            ctag_reg <= TAG_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_BPB: bpb_reg  <= pwdata[15:0];
                REG_HDR: hdr_reg  <= pwdata[7:0];
                REG_TAG: ctag_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BPB: prdata = {16'd0, bpb_reg};
            REG_HDR: prdata = {24'd0, hdr_reg};
            REG_TAG: prdata = {28'd0, ctag_reg};
            default: prdata = '0;
        endcase
    end

    // ---------------- shared units ----------------
    assign accept      = s_valid & s_ready;
    assign div_start   = accept & ~s_action;
    // A block size of zero divides as one.
    assign div_divisor = (bpb_reg == 16'd0) ? 16'd1 : bpb_reg;

    bsa_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (s_request_bytes),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    bsa_map #(
        .MAX_PAGES (MAX_PAGES)
    ) u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (map_cmd),
        .fit        (map_fit),
        .pages_open (pages_open)
    );

    // Ceiling of the quotient, and whether it reaches a full page.
    assign round_up  = |div_rem;
    assign too_large = (|div_quot[31:6]) || (div_quot[5:0] == 6'd63 && round_up);
    assign span_calc = div_quot[5:0] + {5'd0, round_up};

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rel_tag_reg    <= s_release_tag;
            rel_blocks_reg <= s_release_blocks;
            rel_page_reg   <= s_release_page;
            rel_start_reg  <= s_release_start;
        end
        mask_reg       <= mask_next;
        span_reg       <= span_next;
        page_cnt_reg   <= page_cnt_next;
        start_cnt_reg  <= start_cnt_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_start_reg  <= res_start_next;
        res_blocks_reg <= res_blocks_next;
    end

    always_comb begin
        state_next      = state_reg;
        mask_next       = mask_reg;
        span_next       = span_reg;
        page_cnt_next   = page_cnt_reg;
        start_cnt_next  = start_cnt_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_start_next  = res_start_reg;
        res_blocks_next = res_blocks_reg;
        map_cmd         = '{op: MOP_NONE, page: '0, mask: '0, amt: '0};
        out_load        = 1'b0;
        s_ready         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = s_action ? ST_REL : ST_DIV;
                end
            end

            ST_REL: begin
                res_page_next   = '0;
                res_start_next  = '0;
                res_blocks_next = '0;
                if (rel_tag_reg != ctag_reg || {1'b0, rel_page_reg} >= pages_open) begin
                    res_status_next = STAT_CORRUPT;
                end else begin
                    res_status_next = STAT_OK;
                    map_cmd.op      = MOP_FREE;
                    map_cmd.page    = {1'b0, rel_page_reg};
                    map_cmd.mask    = run_mask(rel_blocks_reg);
                    map_cmd.amt     = rel_start_reg;
                end
                state_next = ST_OUT;
            end

            ST_DIV: begin
                if (div_done) begin
                    if (too_large) begin
                        res_status_next = STAT_SPAN;
                        res_page_next   = '0;
                        res_start_next  = '0;
                        res_blocks_next = '0;
                        state_next      = ST_OUT;
                    end else begin
                        mask_next      = run_mask(span_calc);
                        span_next      = span_calc;
                        page_cnt_next  = '0;
                        start_cnt_next = '0;
                        state_next     = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH: begin
                if (page_cnt_reg < pages_open) begin
                    // Test one start position; the map claims the run itself on a fit.
                    map_cmd.op   = MOP_CLAIM;
                    map_cmd.page = page_cnt_reg;
                    map_cmd.mask = mask_reg;
                    map_cmd.amt  = start_cnt_reg;
                    if (map_fit) begin
                        res_status_next = STAT_OK;
                        res_page_next   = page_cnt_reg[2:0];
                        res_start_next  = start_cnt_reg;
                        res_blocks_next = span_reg;
                        state_next      = ST_OUT;
                    end else if (start_cnt_reg == 6'(PAGE_BLOCKS - 1)) begin
                        start_cnt_next = '0;
                        page_cnt_next  = page_cnt_reg + PAGES_W'(1);
                    end else begin
                        start_cnt_next = start_cnt_reg + 6'd1;
                    end
                end else begin
                    // No open page fits: open a fresh page if one is left.
                    res_start_next = '0;
                    if (pages_open < PAGES_W'(MAX_PAGES)) begin
                        map_cmd.op      = MOP_OPEN;
                        map_cmd.mask    = mask_reg;
                        res_status_next = STAT_OK;
                        res_page_next   = pages_open[2:0];
                        res_blocks_next = span_reg;
                    end else begin
                        res_status_next = STAT_NOSPACE;
                        res_page_next   = '0;
                        res_blocks_next = '0;
                    end
                    state_next = ST_OUT;
                end
            end

            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- result register ----------------
    assign stride      = {1'b0, bpb_reg} + {9'd0, hdr_reg};
    assign offset_full = {17'd0, res_start_reg} * {6'd0, stride};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg       <= res_status_reg;
            m_grant_page_reg   <= res_page_reg;
            m_grant_start_reg  <= res_start_reg;
            m_grant_blocks_reg <= res_blocks_reg;
            m_byte_offset_reg  <= offset_full[21:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_grant_page   = m_grant_page_reg;
    assign m_grant_start  = m_grant_start_reg;
    assign m_grant_blocks = m_grant_blocks_reg;
    assign m_byte_offset  = m_byte_offset_reg;

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DIV || state_reg == ST_REL))
        else $error("accepted request did not start work");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |-> (m_grant_page == 3'd0 && m_grant_start == 6'd0
            && m_grant_blocks == 6'd0 && m_byte_offset == 22'd0))
        else $error("error result carries a grant");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid || m_ready)) |=> (m_valid && state_reg == ST_IDLE))
        else $error("finished result was not presented");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

import bsa_pkg::*;

localparam logic ACT_ALLOC   = 1'b0;
localparam logic ACT_RELEASE = 1'b1;

typedef struct packed {
    logic        action;
    logic [31:0] bytes;
    logic [3:0]  tag;
    logic [5:0]  blocks;
    logic [2:0]  page;
    logic [5:0]  start;
} span_request_t;

typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  page;
    logic [5:0]  start;
    logic [5:0]  blocks;
    logic [21:0] offset;
} span_grant_t;

typedef struct packed {
    logic [2:0] page;
    logic [5:0] start;
    logic [5:0] blocks;
} held_run_t;

// Mirrors the free map and registers and keeps the grants still owed by the block.
class grant_tracker;
    logic [63:0]  free_map [MAX_PAGES_DEF];
    int unsigned  pages_open;
    logic [15:0]  block_bytes;
    logic [7:0]   header_bytes;
    logic [3:0]   control_tag;
    span_grant_t  pending_grants[$];
    int unsigned  status_seen[4];
    int unsigned  checked;
    int unsigned  errors;

    function new();
        foreach (free_map[p]) free_map[p] = '1;
        pages_open   = 1;
        block_bytes  = BPB_RESET;
        header_bytes = HDR_RESET;
        control_tag  = TAG_RESET;
        checked      = 0;
        errors       = 0;
        foreach (status_seen[s]) status_seen[s] = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [31:0] value);
        case (index)
            REG_BPB: block_bytes  = value[15:0];
            REG_HDR: header_bytes = value[7:0];
            REG_TAG: control_tag  = value[3:0];
            default: ;
        endcase
    endfunction

    function span_grant_t place_run(logic [31:0] bytes);
        span_grant_t g;
        logic [63:0] divisor;
        logic [63:0] span;
        logic [63:0] run;
        int unsigned pitch;
        int unsigned off;
        g = '0;
        divisor = (block_bytes == 0) ? 64'd1 : {48'd0, block_bytes};
        span = ({32'd0, bytes} + divisor - 64'd1) / divisor;
        if (span >= 64) begin
            g.status = STAT_SPAN;
            return g;
        end
        run = (64'd1 << span) - 64'd1;
        pitch = 32'(block_bytes) + 32'(header_bytes);
        g.blocks = span[5:0];
        for (int p = 0; p < pages_open; p++) begin
            for (int i = 0; i < 64; i++) begin
                if (((free_map[p] >> i) & run) == run) begin
                    free_map[p] &= ~(run << i);
                    off = i * pitch;
                    g.status = STAT_OK;
                    g.page   = 3'(p);
                    g.start  = 6'(i);
                    g.offset = off[21:0];
                    return g;
                end
            end
        end
        // No open page fits, so a fresh page is opened and the run starts at its first block.
        if (pages_open < MAX_PAGES_DEF) begin
            g.status = STAT_OK;
            g.page = 3'(pages_open);
            free_map[pages_open] = ~run;
            pages_open++;
            return g;
        end
        g = '0;
        g.status = STAT_NOSPACE;
        return g;
    endfunction

    function span_grant_t free_run(span_request_t r);
        span_grant_t g;
        logic [63:0] run;
        g = '0;
        if (r.tag != control_tag || r.page >= pages_open) begin
            g.status = STAT_CORRUPT;
            return g;
        end
        run = (64'd1 << r.blocks) - 64'd1;
        free_map[r.page] |= run << r.start;
        g.status = STAT_OK;
        return g;
    endfunction

    function span_grant_t note_request(span_request_t r);
        span_grant_t g;
        g = (r.action == ACT_RELEASE) ? free_run(r) : place_run(r.bytes);
        pending_grants.push_back(g);
        status_seen[g.status]++;
        return g;
    endfunction

    task report_mismatch(string what);
        $display("[%0t] result %0d mismatch: %s", $time, checked, what);
        errors++;
    endtask

    task check_result(span_grant_t got);
        span_grant_t want;
        if (pending_grants.size() == 0) begin
            report_mismatch($sformatf("result with status %0d but no request outstanding",
                                      got.status));
            return;
        end
        want = pending_grants.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
        if (got.page !== want.page)
            report_mismatch($sformatf("grant_page %0d, wanted %0d", got.page, want.page));
        if (got.start !== want.start)
            report_mismatch($sformatf("grant_start %0d, wanted %0d", got.start, want.start));
        if (got.blocks !== want.blocks)
            report_mismatch($sformatf("grant_blocks %0d, wanted %0d", got.blocks, want.blocks));
        if (got.offset !== want.offset)
            report_mismatch($sformatf("byte_offset %0d, wanted %0d", got.offset, want.offset));
        checked++;
    endtask
endclass

module tb;
    logic        aclk;
    logic        aresetn          = 1'b0;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [3:0]  paddr            = '0;
    logic [31:0] pwdata           = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic        s_action         = 1'b0;
    logic [31:0] s_request_bytes  = '0;
    logic [3:0]  s_release_tag    = '0;
    logic [5:0]  s_release_blocks = '0;
    logic [2:0]  s_release_page   = '0;
    logic [5:0]  s_release_start  = '0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [1:0]  m_status;
    logic [2:0]  m_grant_page;
    logic [5:0]  m_grant_start;
    logic [5:0]  m_grant_blocks;
    logic [21:0] m_byte_offset;

    grant_tracker tracker = new();
    held_run_t    held_runs[$];
    int unsigned  requests_sent = 0;
    int unsigned  results_seen  = 0;

    bitmap_span_allocator dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("timeout after %0d requests and %0d results", requests_sent, results_seen);
        $display("bitmap_span_allocator test failed");
        $finish;
    end

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_register(index, value);
        @(posedge aclk);
    endtask

    function automatic span_request_t alloc_req(input logic [31:0] bytes);
        span_request_t r;
        r = {ACT_ALLOC, bytes, 4'($urandom), 6'($urandom), 3'($urandom), 6'($urandom)};
        return r;
    endfunction

    function automatic span_request_t release_req(input logic [3:0] tag,
                                                  input logic [5:0] blocks,
                                                  input logic [2:0] page,
                                                  input logic [5:0] start);
        span_request_t r;
        r = {ACT_RELEASE, $urandom, tag, blocks, page, start};
        return r;
    endfunction

    // Mostly allocations of modest runs and releases of runs granted earlier,
    // with some oversized requests and releases carrying arbitrary headers.
    function automatic span_request_t random_request();
        span_request_t r;
        held_run_t     h;
        logic [31:0]   unit;
        int unsigned   n;
        int unsigned   k;
        int unsigned   pick;
        r = {1'b0, $urandom, 4'($urandom), 6'($urandom), 3'($urandom), 6'($urandom)};
        unit = (tracker.block_bytes == 0) ? 32'd1 : {16'd0, tracker.block_bytes};
        if (held_runs.size() == 0 || $urandom_range(0, 99) < 55) begin
            r.action = ACT_ALLOC;
            k = $urandom_range(0, 99);
            if (k < 5) begin
                r.bytes = '0;
            end else if (k < 8) begin
                r.bytes = $urandom;
            end else if (k < 10) begin
                r.bytes = 64 * unit - $urandom_range(0, unit - 1);
            end else begin
                n = (k < 75) ? $urandom_range(1, 16) : $urandom_range(17, 63);
                r.bytes = (n - 1) * unit + $urandom_range(1, unit);
            end
        end else begin
            r.action = ACT_RELEASE;
            if ($urandom_range(0, 4) != 0) begin
                pick = $urandom_range(0, held_runs.size() - 1);
                h = held_runs[pick];
                held_runs.delete(pick);
                r.tag    = tracker.control_tag;
                r.page   = h.page;
                r.start  = h.start;
                r.blocks = h.blocks;
            end else if ($urandom_range(0, 2) != 0) begin
                r.tag = tracker.control_tag;
            end
        end
        return r;
    endfunction

    task automatic send_request(input span_request_t r);
        int unsigned gap;
        span_grant_t g;
        gap = (((requests_sent / 50) % 5) == 4) ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_action         <= r.action;
        s_request_bytes  <= r.bytes;
        s_release_tag    <= r.tag;
        s_release_blocks <= r.blocks;
        s_release_page   <= r.page;
        s_release_start  <= r.start;
        do @(posedge aclk); while (!s_ready);
        g = tracker.note_request(r);
        requests_sent++;
        if (r.action == ACT_ALLOC && g.status == STAT_OK && g.blocks != 0)
            held_runs.push_back({g.page, g.start, g.blocks});
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending_grants.size() != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input int unsigned count);
        repeat (count) send_request(random_request());
        drain();
    endtask

    // Result side. One long hold-off lets the block fill and push back on requests.
    initial begin
        int unsigned stall;
        span_grant_t got;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (results_seen == 250)
                stall = 3000;
            else if (((results_seen / 60) % 4) == 3)
                stall = 0;
            else
                stall = $urandom_range(0, 11);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.status = m_status;
            got.page   = m_grant_page;
            got.start  = m_grant_start;
            got.blocks = m_grant_blocks;
            got.offset = m_byte_offset;
            tracker.check_result(got);
            results_seen++;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: 4096-byte blocks, 16-byte headers, tag 10.
        send_request(alloc_req(32'd0));
        send_request(alloc_req(32'd1));
        send_request(alloc_req(32'd4096));
        send_request(alloc_req(32'd4097));
        send_request(alloc_req(32'd258048));
        send_request(alloc_req(32'd258049));
        send_request(alloc_req(32'hFFFF_FFFF));
        send_request(release_req(4'd5, 6'd1, 3'd0, 6'd1));
        send_request(release_req(TAG_RESET, 6'd4, 3'd7, 6'd0));
        send_request(release_req(TAG_RESET, 6'd1, 3'd0, 6'd1));
        send_request(release_req(TAG_RESET, 6'd63, 3'd0, 6'd60));
        send_request(release_req(TAG_RESET, 6'd5, 3'd0, 6'd10));
        send_request(release_req(TAG_RESET, 6'd0, 3'd1, 6'd0));
        send_request(alloc_req(32'd249856));
        // 63-block runs open every remaining page and then run out of space.
        repeat (6) send_request(alloc_req(32'd258048));
        send_request(release_req(4'd15, 6'd63, 3'd7, 6'd63));
        send_request(release_req(TAG_RESET, 6'd63, 3'd7, 6'd63));
        send_request(release_req(4'd0, 6'd0, 3'd0, 6'd0));
        drain();

        run_phase(180);

        write_register(REG_BPB, 32'd1);
        write_register(REG_HDR, 32'd0);
        write_register(REG_TAG, 32'd0);
        run_phase(180);

        write_register(REG_BPB, 32'd65535);
        write_register(REG_HDR, 32'd255);
        write_register(REG_TAG, 32'd15);
        run_phase(180);

        // A block size of zero divides as one.
        write_register(REG_BPB, 32'd0);
        write_register(REG_HDR, $urandom_range(0, 255));
        write_register(REG_TAG, $urandom_range(0, 15));
        run_phase(180);

        write_register(REG_BPB, $urandom_range(100, 9000));
        write_register(REG_HDR, $urandom_range(0, 255));
        write_register(REG_TAG, $urandom_range(0, 15));
        run_phase(180);

        repeat (600) @(posedge aclk);
        $display("%0d requests over five register settings: %0d ok, %0d out of space,",
                 requests_sent, tracker.status_seen[STAT_OK],
                 tracker.status_seen[STAT_NOSPACE]);
        $display("%0d oversized, %0d bad headers; %0d results checked, %0d mismatches",
                 tracker.status_seen[STAT_SPAN], tracker.status_seen[STAT_CORRUPT],
                 tracker.checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("bitmap_span_allocator test passed");
        end else begin
            $display("bitmap_span_allocator test failed");
        end
        $finish;
    end
endmodule

// ----- bitmap_span_allocator.f -----
sv/bsa_pkg.sv
sv/bsa_divider.sv
sv/bsa_map.sv
sv/bitmap_span_allocator.sv
test/tb.sv
